### design/tfn_pkg.sv
// Shared widths, stage counts and payload types of the triangle face normal block.
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

	// Default coordinate width (signed Q8.8)
	localparam int COORD_WIDTH_DEF = 16;
	// Coordinates wider than this get their edges pre-shifted so each edge product fits 62 bits
	localparam int EDGE_CAP = 30;

	// Block-scaled cross magnitudes lie below 2^31
	localparam int MAG_W = 31;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W = ROOT_W + 4;

	// Output format: signed Q1.14
	localparam int NORM_W = 16;
	localparam int NORM_FRAC = 14;
	localparam int QUO_W = NORM_FRAC + 1;
	localparam int NUM_W = MAG_W + NORM_FRAC + 1;

	// Pipeline depths
	localparam int FRONT_STAGES = 7;
	localparam int BACK_STAGES = 2 + ROOT_W + 1 + QUO_W + 1;

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// Classified triangle handed from front to back
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} mid_t;

	// Finished normal
	typedef struct packed {
		logic [NORM_W-1:0] nx;
		logic [NORM_W-1:0] ny;
		logic [NORM_W-1:0] nz;
		logic              degen;
	} norm_t;

endpackage

`default_nettype wire

### design/tfn_fifo.sv
// Small first-word-fall-through queue used between pipeline sections.
`timescale 1ns / 1ps
`default_nettype none

module tfn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign dout  = mem_q[rd_q];

	// Store the incoming transfer
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/tfn_front.sv
// Front pipeline: edges, cross product, degenerate check and block scaling.
`timescale 1ns / 1ps
`default_nettype none

module tfn_front #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_full,
	input  logic signed [COORD_WIDTH-1:0] vtx_a [3],
	input  logic signed [COORD_WIDTH-1:0] vtx_b [3],
	input  logic signed [COORD_WIDTH-1:0] vtx_c [3],
	output logic                          out_valid,
	input  logic                          out_full,
	output tfn_pkg::mid_t                 out_item
);

	localparam int CW   = COORD_WIDTH;
	localparam int EW   = ((CW > tfn_pkg::EDGE_CAP) ? tfn_pkg::EDGE_CAP : CW) + 1;
	localparam int PRE  = (CW > tfn_pkg::EDGE_CAP) ? CW - tfn_pkg::EDGE_CAP : 0;
	localparam int PW   = 2 * EW;
	localparam int XW   = PW + 1;
	localparam int MXW  = PW - 1;
	localparam int NG   = (MXW + 7) / 8;
	localparam int BLW  = $clog2(MXW + 1);
	localparam int SHW  = MXW + tfn_pkg::MAG_W;
	localparam int NST  = tfn_pkg::FRONT_STAGES;

	// Edge p - o, magnitude shifted toward zero for wide coordinates
	function automatic logic signed [EW-1:0] edge_of(
		input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] o
	);
		logic [CW:0] d;
		logic [CW:0] m;
		logic [CW:0] s;
		d = {p[CW-1], p} - {o[CW-1], o};
		m = d[CW] ? (~d + 1'b1) : d;
		s = m >> PRE;
		edge_of = d[CW] ? EW'(-$signed(s[EW-1:0])) : $signed(s[EW-1:0]);
	endfunction

	logic [NST-1:0] vld_q;
	logic           adv;

	logic signed [EW-1:0]  e1_s1   [3];
	logic signed [EW-1:0]  e2_s1   [3];
	logic signed [PW-1:0]  prod_s2 [6];
	logic signed [XW-1:0]  cross_s3 [3];
	logic [MXW-1:0]        mag_s4  [3];
	logic [2:0]            neg_s4;
	logic [MXW-1:0]        or_s4;
	logic [MXW-1:0]        mag_s5  [3];
	logic [2:0]            neg_s5;
	logic [3:0]            glen_s5 [NG];
	logic [MXW-1:0]        mag_s6  [3];
	logic [2:0]            neg_s6;
	logic [BLW-1:0]        bl_s6;
	tfn_pkg::mid_t         item_s7;

	logic [XW-1:0]         abs_c   [3];
	logic [NG*8-1:0]       or_pad;
	logic [3:0]            glen_c  [NG];
	logic [BLW-1:0]        bl_c;
	logic [SHW-1:0]        shw_c   [3];

	// Stall the whole section only when the last stage cannot leave
	assign adv       = !vld_q[NST-1] || !out_full;
	assign in_full   = !adv;
	assign out_valid = vld_q[NST-1];
	assign out_item  = item_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Magnitudes of cross components, group bit lengths of their OR, total bit length and scaled magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = cross_s3[i][XW-1] ? (~cross_s3[i] + 1'b1) : cross_s3[i];
		end
		or_pad = (NG*8)'(or_s4);
		for (int g = 0; g < NG; g++) begin
			glen_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (or_pad[g*8 + b]) begin
					glen_c[g] = 4'(b + 1);
				end
			end
		end
		bl_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (glen_s5[g] != '0) begin
				bl_c = BLW'(g * 8) + BLW'(glen_s5[g]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			shw_c[i] = {mag_s6[i], {tfn_pkg::MAG_W{1'b0}}} >> bl_s6;
		end
	end

	// Advance the payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= edge_of(vtx_b[i], vtx_a[i]);
				e2_s1[i] <= edge_of(vtx_c[i], vtx_a[i]);
			end

			prod_s2[0] <= e1_s1[1] * e2_s1[2];
			prod_s2[1] <= e1_s1[2] * e2_s1[1];
			prod_s2[2] <= e1_s1[2] * e2_s1[0];
			prod_s2[3] <= e1_s1[0] * e2_s1[2];
			prod_s2[4] <= e1_s1[0] * e2_s1[1];
			prod_s2[5] <= e1_s1[1] * e2_s1[0];

			for (int i = 0; i < 3; i++) begin
				cross_s3[i] <= {prod_s2[2*i][PW-1], prod_s2[2*i]}
					- {prod_s2[2*i+1][PW-1], prod_s2[2*i+1]};
			end

			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= abs_c[i][MXW-1:0];
				neg_s4[i] <= cross_s3[i][XW-1];
			end
			or_s4 <= abs_c[0][MXW-1:0] | abs_c[1][MXW-1:0] | abs_c[2][MXW-1:0];

			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			glen_s5 <= glen_c;

			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
			bl_s6  <= bl_c;

			for (int i = 0; i < 3; i++) begin
				item_s7.mag[i] <= shw_c[i][tfn_pkg::MAG_W-1:0];
			end
			item_s7.neg   <= neg_s6;
			item_s7.degen <= (bl_s6 == '0);
		end
	end

endmodule

`default_nettype wire

### design/tfn_back.sv
// Back pipeline: sum of squares, digit-by-digit square root, division and sign.
`timescale 1ns / 1ps
`default_nettype none

module tfn_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  tfn_pkg::mid_t  in_item,
	output logic           in_pop,
	output logic           out_valid,
	input  logic           out_full,
	output tfn_pkg::norm_t out_item
);

	localparam int NST   = tfn_pkg::BACK_STAGES;
	localparam int SQ_W  = tfn_pkg::SQ_W;
	localparam int SUM_W = tfn_pkg::SUM_W;
	localparam int ROOT_W = tfn_pkg::ROOT_W;
	localparam int REM_W = tfn_pkg::REM_W;
	localparam int QUO_W = tfn_pkg::QUO_W;
	localparam int NUM_W = tfn_pkg::NUM_W;
	localparam int NORM_W = tfn_pkg::NORM_W;
	localparam int NORM_FRAC = tfn_pkg::NORM_FRAC;

	logic [NST-1:0] vld_q;
	logic           adv;

	logic [SQ_W-1:0]   sq_s1  [3];
	tfn_pkg::mid_t     side_s1;
	logic [SUM_W-1:0]  sum_s2;
	tfn_pkg::mid_t     side_s2;

	logic [REM_W-1:0]  rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W];
	logic [SUM_W-1:0]  rt_sum_s  [ROOT_W];
	tfn_pkg::mid_t     rt_side_s [ROOT_W];

	logic [ROOT_W-1:0] pr_rem_s35 [3];
	logic [QUO_W-1:0]  pr_low_s35 [3];
	logic [ROOT_W-1:0] pr_len_s35;
	tfn_pkg::mid_t     pr_side_s35;

	logic [ROOT_W-1:0] dv_rem_s  [QUO_W][3];
	logic [QUO_W-1:0]  dv_low_s  [QUO_W][3];
	logic [QUO_W-1:0]  dv_quo_s  [QUO_W][3];
	logic [ROOT_W-1:0] dv_len_s  [QUO_W];
	tfn_pkg::mid_t     dv_side_s [QUO_W];

	tfn_pkg::norm_t    res_s51;

	logic [NUM_W-1:0]  num_c [3];
	logic [NORM_W-1:0] nrm_c [3];

	assign adv       = !vld_q[NST-1] || !out_full;
	assign in_pop    = in_valid && adv;
	assign out_valid = vld_q[NST-1];
	assign out_item  = res_s51;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Square and sum the scaled magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= in_item.mag[i] * in_item.mag[i];
			end
			side_s1 <= in_item;
			sum_s2  <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			side_s2 <= side_s1;
		end
	end

	// Square root: one result bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SUM_W-1:0]  sum_in;
		tfn_pkg::mid_t     side_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              fits;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign sum_in  = sum_s2;
			assign side_in = side_s2;
		end else begin : g_next
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign sum_in  = rt_sum_s[k-1];
			assign side_in = rt_side_s[k-1];
		end

		assign rem_sh = {rem_in[REM_W-3:0], sum_in[SUM_W-1-2*k -: 2]};
		assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
		assign fits   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[k]  <= fits ? rem_sh - trial : rem_sh;
				rt_root_s[k] <= {root_in[ROOT_W-2:0], fits};
				rt_sum_s[k]  <= sum_in;
				rt_side_s[k] <= side_in;
			end
		end
	end

	// Form rounded numerators and seed the dividers with their top bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = NUM_W'({rt_side_s[ROOT_W-1].mag[i], {NORM_FRAC{1'b0}}})
				+ NUM_W'(rt_root_s[ROOT_W-1][ROOT_W-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pr_rem_s35[i] <= ROOT_W'(num_c[i][NUM_W-1:QUO_W]);
				pr_low_s35[i] <= num_c[i][QUO_W-1:0];
			end
			pr_len_s35  <= rt_root_s[ROOT_W-1];
			pr_side_s35 <= rt_side_s[ROOT_W-1];
		end
	end

	// Restoring division: one quotient bit per stage, three lanes
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic [ROOT_W-1:0] len_in;
		tfn_pkg::mid_t     side_in;

		if (j == 0) begin : g_first
			assign len_in  = pr_len_s35;
			assign side_in = pr_side_s35;
		end else begin : g_next
			assign len_in  = dv_len_s[j-1];
			assign side_in = dv_side_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_len_s[j]  <= len_in;
				dv_side_s[j] <= side_in;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [ROOT_W-1:0] rem_in;
			logic [QUO_W-1:0]  low_in;
			logic [QUO_W-1:0]  quo_in;
			logic [ROOT_W:0]   rem_sh;
			logic              fits;

			if (j == 0) begin : g_first
				assign rem_in = pr_rem_s35[l];
				assign low_in = pr_low_s35[l];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = dv_rem_s[j-1][l];
				assign low_in = dv_low_s[j-1][l];
				assign quo_in = dv_quo_s[j-1][l];
			end

			assign rem_sh = {rem_in, low_in[QUO_W-1-j]};
			assign fits   = (rem_sh >= {1'b0, len_in});

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[j][l] <= fits ? ROOT_W'(rem_sh - {1'b0, len_in})
						: ROOT_W'(rem_sh);
					dv_low_s[j][l] <= low_in;
					dv_quo_s[j][l] <= {quo_in[QUO_W-2:0], fits};
				end
			end
		end
	end

	// Apply signs; force zero on a degenerate triangle
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_side_s[QUO_W-1].degen) begin
				nrm_c[i] = '0;
			end else if (dv_side_s[QUO_W-1].neg[i]) begin
				nrm_c[i] = NORM_W'(-NORM_W'(dv_quo_s[QUO_W-1][i]));
			end else begin
				nrm_c[i] = NORM_W'(dv_quo_s[QUO_W-1][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s51.nx    <= nrm_c[0];
			res_s51.ny    <= nrm_c[1];
			res_s51.nz    <= nrm_c[2];
			res_s51.degen <= dv_side_s[QUO_W-1].degen;
		end
	end

endmodule

`default_nettype wire

### design/triangle_face_normal.sv
// Top level of the triangle face normal block: front, queues and back.
//
// Usage: write one triangle (vertices a, b, c, signed Q8.8 at the default
// COORD_WIDTH) with push while full is low; each transfer yields exactly one
// result, a unit normal in signed Q1.14 plus a degenerate flag (normal zero).
// Results are read like a queue: while empty is low the oldest result is on
// normal_x/y/z and degenerate, and pop takes it.
// Throughput: one triangle per cycle, sustained while results are popped, because every step is a
// pipeline stage; the square root costs one stage per root bit (32) and the
// division one stage per quotient bit (15).
// Path: a result passes through 7 front stages, the front/back queue,
// 51 back stages and the output queue before it shows on the output ports.
// Stalls: when pop is held off, the output queue fills, the back pipeline
// freezes, then the middle queue fills and the front freezes; full rises only
// then. No item is lost or repeated.
// Reset: arst_n clears all queues and valid flags; the block is ready at once.
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] az,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by_coord,
	input  logic signed [COORD_WIDTH-1:0] bz,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] cz,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [tfn_pkg::NORM_W-1:0] normal_x,
	output logic signed [tfn_pkg::NORM_W-1:0] normal_y,
	output logic signed [tfn_pkg::NORM_W-1:0] normal_z,
	output logic                          degenerate
);

	localparam int MID_W = $bits(tfn_pkg::mid_t);
	localparam int OUT_W = $bits(tfn_pkg::norm_t);

	logic signed [COORD_WIDTH-1:0] vtx_a [3];
	logic signed [COORD_WIDTH-1:0] vtx_b [3];
	logic signed [COORD_WIDTH-1:0] vtx_c [3];

	logic              fr_valid;
	tfn_pkg::mid_t     fr_item;
	logic              mid_full;
	logic              mid_empty;
	logic [MID_W-1:0]  mid_dout;
	tfn_pkg::mid_t     mid_item;
	logic              bk_pop;
	logic              bk_valid;
	tfn_pkg::norm_t    bk_item;
	logic              out_full;
	logic [OUT_W-1:0]  out_dout;
	tfn_pkg::norm_t    res;

	// Gather vertices
	assign vtx_a[0] = ax;
	assign vtx_a[1] = ay;
	assign vtx_a[2] = az;
	assign vtx_b[0] = bx;
	assign vtx_b[1] = by_coord;
	assign vtx_b[2] = bz;
	assign vtx_c[0] = cx;
	assign vtx_c[1] = cy;
	assign vtx_c[2] = cz;

	tfn_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_full  (full),
		.vtx_a    (vtx_a),
		.vtx_b    (vtx_b),
		.vtx_c    (vtx_c),
		.out_valid(fr_valid),
		.out_full (mid_full),
		.out_item (fr_item)
	);

	tfn_fifo #(
		.WIDTH(MID_W),
		.DEPTH(tfn_pkg::MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid),
		.din   (fr_item),
		.full  (mid_full),
		.pop   (bk_pop),
		.dout  (mid_dout),
		.empty (mid_empty)
	);

	assign mid_item = mid_dout;

	tfn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_item),
		.in_pop   (bk_pop),
		.out_valid(bk_valid),
		.out_full (out_full),
		.out_item (bk_item)
	);

	tfn_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(tfn_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (bk_valid),
		.din   (bk_item),
		.full  (out_full),
		.pop   (pop),
		.dout  (out_dout),
		.empty (empty)
	);

	// Present the oldest result
	assign res        = out_dout;
	assign normal_x   = $signed(res.nx);
	assign normal_y   = $signed(res.ny);
	assign normal_z   = $signed(res.nz);
	assign degenerate = res.degen;

endmodule

`default_nettype wire
